### src/svq_pkg.sv
// svq_pkg: shared types and constants for the sorted value queue.
// Request/response beat structs, op codes, FSM states, controller/datapath links.
package svq_pkg;

   localparam int CAPACITY = 64;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_POP_MIN = 3'd1,
      OP_POP_MAX = 3'd2,
      OP_READ    = 3'd3,
      OP_CLEAR   = 3'd4
   } svq_op_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [5:0]         position;
   } svq_req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] result_value;
      logic [6:0]         count;
   } svq_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_LAST
   } svq_state_type;

   typedef enum logic [2:0] {
      ADDR_ZERO,
      ADDR_LAST,
      ADDR_POS,
      ADDR_IDX,
      ADDR_IDX_NEXT
   } svq_addr_type;

   typedef enum logic [1:0] {
      FILL_HOLD,
      FILL_INC,
      FILL_DEC,
      FILL_CLEAR
   } svq_fill_type;

   typedef struct packed {
      logic         latch;
      svq_addr_type addr_sel;
      logic         wr_en;
      logic         wr_rdata;   // 1: write read data (shift), 0: write new value
      logic         idx_load;
      logic         idx_dec;
      svq_fill_type fill_op;
      logic         head_inc;
      logic         head_clear;
      logic         rsp_load;
      logic         rsp_ok;
      logic         rsp_use_data;
   } svq_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       empty;
      logic       pos_in_range;
      logic       rd_greater;
      logic       idx_zero;
   } svq_status_type;

endpackage

### src/sorted_value_queue.sv
// sorted_value_queue: ascending store of signed values in a ring memory, one op at a time.
// Clear, failed ops and insert into empty are answered from the decode state; remove and
// read go through a registered memory read; insert runs a read/compare/shift loop on the
// one RAM port over the stored values greater than the new one.
// busy drops in the strobe cycle, so a new op can start in it. The result strobe lasts
// one cycle and cannot be stalled. Synchronous reset empties the store; contents undefined.
module sorted_value_queue
   import svq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  svq_req_type req_data,
   output logic        rsp_strobe,
   output svq_rsp_type rsp_data
);

   svq_cmd_type    cmd;
   svq_status_type status;

   svq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   svq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### src/svq_dpath.sv
// svq_dpath: entry memory (circular, kept sorted), head/fill/index registers,
// request latch and response register. Depends on svq_pkg.
module svq_dpath
   import svq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  svq_req_type    req_data,
   input  svq_cmd_type    cmd,
   output svq_status_type status,
   output logic           rsp_strobe,
   output svq_rsp_type    rsp_data
);

   logic [31:0]    entries_mem [CAPACITY];
   logic [31:0]    rd_data_ff;
   svq_req_type    req_ff;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           rsp_strobe_ff;
   svq_rsp_type    rsp_ff;
   logic [AW-1:0]  logical;
   logic [AW:0]    sum;
   logic [AW-1:0]  phys;
   logic [31:0]    wdata;
   logic [CW+5:0]  pos_ext, fill_ext;

   // logical position -> physical address, wrap around the ring
   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_ZERO:     logical = '0;
         ADDR_LAST:     logical = AW'(fill_ff - 1'b1);
         ADDR_POS:      logical = AW'(req_ff.position);
         ADDR_IDX:      logical = idx_ff;
         ADDR_IDX_NEXT: logical = AW'(idx_ff + 1'b1);
         default:       logical = '0;
      endcase
      sum = {1'b0, head_ff} + {1'b0, logical};
      if (sum >= (AW + 1)'(CAPACITY)) begin
         phys = AW'(sum - (AW + 1)'(CAPACITY));
      end else begin
         phys = AW'(sum);
      end
      wdata = cmd.wr_rdata ? rd_data_ff : req_ff.value;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_mem[phys] <= wdata;
      end
      rd_data_ff <= entries_mem[phys];
      if (cmd.latch) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.head_clear) begin
         head_in = '0;
      end else if (cmd.head_inc) begin
         head_in = (head_ff == AW'(CAPACITY - 1)) ? '0 : AW'(head_ff + 1'b1);
      end

      unique case (cmd.fill_op)
         FILL_INC:   fill_in = CW'(fill_ff + 1'b1);
         FILL_DEC:   fill_in = CW'(fill_ff - 1'b1);
         FILL_CLEAR: fill_in = '0;
         default:    fill_in = fill_ff;
      endcase

      idx_in = idx_ff;
      if (cmd.idx_load) begin
         idx_in = AW'(fill_ff - 1'b1);
      end else if (cmd.idx_dec) begin
         idx_in = AW'(idx_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
      idx_ff <= idx_in;
      if (cmd.rsp_load) begin
         rsp_ff.ok           <= cmd.rsp_ok;
         rsp_ff.result_value <= cmd.rsp_use_data ? $signed(rd_data_ff) : 32'sd0;
         rsp_ff.count        <= 7'(fill_in);
      end
   end

   assign pos_ext  = (CW + 6)'(req_ff.position);
   assign fill_ext = (CW + 6)'(fill_ff);

   assign status.op           = req_ff.op;
   assign status.full         = (fill_ff == CW'(CAPACITY));
   assign status.empty        = (fill_ff == '0);
   assign status.pos_in_range = (pos_ext < fill_ext);
   assign status.rd_greater   = ($signed(rd_data_ff) > req_ff.value);
   assign status.idx_zero     = (idx_ff == '0);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### src/svq_ctrl.sv
// svq_ctrl: operation sequencer for the sorted value queue.
// Drives svq_dpath through svq_cmd_type; depends on svq_pkg.
module svq_ctrl
   import svq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  svq_status_type status,
   output svq_cmd_type    cmd
);

   svq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd.latch        = 1'b0;
      cmd.addr_sel     = ADDR_ZERO;
      cmd.wr_en        = 1'b0;
      cmd.wr_rdata     = 1'b0;
      cmd.idx_load     = 1'b0;
      cmd.idx_dec      = 1'b0;
      cmd.fill_op      = FILL_HOLD;
      cmd.head_inc     = 1'b0;
      cmd.head_clear   = 1'b0;
      cmd.rsp_load     = 1'b0;
      cmd.rsp_ok       = 1'b0;
      cmd.rsp_use_data = 1'b0;
      busy             = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            unique case (status.op) inside
               OP_INSERT: begin
                  if (status.full) begin
                     cmd.rsp_load = 1'b1;
                  end else if (status.empty) begin
                     cmd.addr_sel = ADDR_ZERO;
                     cmd.wr_en    = 1'b1;
                     cmd.fill_op  = FILL_INC;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_ok   = 1'b1;
                  end else begin
                     cmd.idx_load = 1'b1;
                     state_in     = ST_INS_RD;
                  end
               end
               OP_POP_MIN, OP_POP_MAX: begin
                  cmd.addr_sel = (status.op == OP_POP_MIN) ? ADDR_ZERO : ADDR_LAST;
                  if (status.empty) begin
                     cmd.rsp_load = 1'b1;
                  end else begin
                     state_in = ST_RD_WAIT;
                  end
               end
               OP_READ: begin
                  cmd.addr_sel = ADDR_POS;
                  if (status.pos_in_range) begin
                     state_in = ST_RD_WAIT;
                  end else begin
                     cmd.rsp_load = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  cmd.fill_op    = FILL_CLEAR;
                  cmd.head_clear = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_ok     = 1'b1;
               end
               default: begin
                  cmd.rsp_load = 1'b1;
               end
            endcase
         end

         // read data from the address issued in ST_DECODE is valid here
         ST_RD_WAIT: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_ok       = 1'b1;
            cmd.rsp_use_data = 1'b1;
            if (status.op == OP_POP_MIN) begin
               cmd.head_inc = 1'b1;
               cmd.fill_op  = FILL_DEC;
            end else if (status.op == OP_POP_MAX) begin
               cmd.fill_op = FILL_DEC;
            end
            state_in = ST_IDLE;
         end

         ST_INS_RD: begin
            cmd.addr_sel = ADDR_IDX;
            state_in     = ST_INS_CMP;
         end

         // walk down from the top: shift larger entries up one, drop value in the gap
         ST_INS_CMP: begin
            cmd.addr_sel = ADDR_IDX_NEXT;
            cmd.wr_en    = 1'b1;
            if (status.rd_greater) begin
               cmd.wr_rdata = 1'b1;
               if (status.idx_zero) begin
                  state_in = ST_INS_LAST;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = ST_INS_RD;
               end
            end else begin
               cmd.fill_op  = FILL_INC;
               cmd.rsp_load = 1'b1;
               cmd.rsp_ok   = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_INS_LAST: begin
            cmd.addr_sel = ADDR_ZERO;
            cmd.wr_en    = 1'b1;
            cmd.fill_op  = FILL_INC;
            cmd.rsp_load = 1'b1;
            cmd.rsp_ok   = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
